// ===== hdl/rbgr_pkg.sv =====
// rbgr_pkg: shared types and codes for the rbsp bit reader
// no dependencies
`default_nettype none
package rbgr_pkg;
    typedef enum logic [2:0] {
        FUNC_LOAD = 3'd0,
        FUNC_READ = 3'd1,
        FUNC_SKIP = 3'd2,
        FUNC_UE   = 3'd3,
        FUNC_SE   = 3'd4,
        FUNC_MORE = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PAST    = 2'd1,
        ST_LONG    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_value;
        logic       last_byte;
        logic [5:0] bit_count;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        more_data;
        logic [1:0]  status;
    } rsp_t;
endpackage
`default_nettype wire

// ===== hdl/rbgr_if.sv =====
// rbgr_req_if / rbgr_rsp_if: valid-ready channels
// depends on rbgr_pkg
`default_nettype none
interface rbgr_req_if;
    logic valid;
    logic ready;
    rbgr_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rbgr_rsp_if;
    logic valid;
    logic ready;
    rbgr_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/rbgr_front.sv =====
// rbgr_front: accepts requests, drops unknown codes, two-entry queue to back end
// depends on rbgr_pkg, rbgr_if
`default_nettype none
module rbgr_front (
    input  wire logic clk,
    input  wire logic rst_n,
    rbgr_req_if.sink  req,
    output rbgr_pkg::req_t q_data,
    output logic      q_valid,
    input  wire logic q_pop
);
    import rbgr_pkg::*;

    req_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign req.ready = (cnt_reg != 2'd2);
    assign push = req.valid && req.ready && (req.payload.func <= FUNC_MORE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = wp_reg ^ push;
        rp_next = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= req.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rbgr_back.sv =====
// rbgr_back: byte store and bit-serial sequencer for reads, skips, codes, tests
// depends on rbgr_pkg, rbgr_if
`default_nettype none
module rbgr_back #(
    parameter int BUFFER_BYTES = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  rbgr_pkg::req_t q_data,
    input  wire logic q_valid,
    output logic      q_pop,
    rbgr_rsp_if.source rsp
);
    import rbgr_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = $clog2(BUFFER_BYTES * 8 + 1);
    localparam int LW = PW + 1;
    localparam logic [PW-1:0] CAP = PW'(BUFFER_BYTES * 8);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_BIT   = 9'b000000100,
        S_E0    = 9'b000001000,
        S_E1    = 9'b000010000,
        S_E2    = 9'b000100000,
        S_EDONE = 9'b001000000,
        S_TRIM  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        M_READ = 3'b001,
        M_PRE  = 3'b010,
        M_MORE = 3'b100
    } mode_t;

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rd_reg;
    logic [AW-1:0] ra;
    logic re;

    state_t state_reg, state_next;
    mode_t mode_reg, mode_next;
    logic [PW-1:0] pos_reg, pos_next, spos_reg, spos_next;
    logic [LW-1:0] left_reg, left_next, sleft_reg, sleft_next;
    logic [CW-1:0] nb_reg, nb_next;
    logic [AW-1:0] lnz_i_reg, lnz_i_next;
    logic [7:0] lnz_v_reg, lnz_v_next;
    logic closed_reg, closed_next;
    logic [5:0] n_reg, n_next, z_reg, z_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0] fn_reg, fn_next;
    logic past_reg, past_next, long_reg, long_next, more_reg, more_next;
    logic [2:0] sh_reg, sh_next;
    logic ov_reg;
    logic [1:0] st_reg, st_next;
    logic e_ok_reg, e_ok_next;
    logic [AW-1:0] ek_reg, ek_next;
    logic [PW-1:0] padd;
    logic [PW:0] ptmp;
    logic [PW:0] nbits;
    logic inrange, bitv;
    logic [PW-1:0] p1;
    logic [31:0] x;
    logic [5:0] nsat;

    assign nsat = (q_data.bit_count > 6'd32) ? 6'd32 : q_data.bit_count;
    assign nbits = (PW+1)'({nb_reg, 3'b000});
    assign inrange = ({1'b0, pos_reg} < nbits);
    assign bitv = inrange ? rd_reg[3'd7 - pos_reg[2:0]] : 1'b0;
    assign p1 = (pos_reg >= CAP) ? CAP : pos_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_data.func == FUNC_LOAD
            && (closed_reg || nb_reg < CW'(BUFFER_BYTES)))
        begin
            mem[closed_reg ? AW'(0) : nb_reg[AW-1:0]] <= q_data.byte_value;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    always_comb
    begin
        state_next = state_reg; mode_next = mode_reg; pos_next = pos_reg;
        spos_next = spos_reg; left_next = left_reg; sleft_next = sleft_reg;
        nb_next = nb_reg; lnz_i_next = lnz_i_reg; lnz_v_next = lnz_v_reg;
        closed_next = closed_reg; n_next = n_reg; z_next = z_reg; acc_next = acc_reg;
        fn_next = fn_reg; past_next = past_reg; long_next = long_reg;
        more_next = more_reg; sh_next = sh_reg; st_next = st_reg;
        e_ok_next = e_ok_reg; ek_next = ek_reg;
        q_pop = 1'b0; re = 1'b0; ra = pos_reg[AW+2:3];
        ptmp = '0; padd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    fn_next = q_data.func;
                    past_next = 1'b0; long_next = 1'b0; more_next = 1'b0;
                    acc_next = '0; z_next = '0; st_next = ST_OK;
                    n_next = nsat;
                    unique case (q_data.func)
                        FUNC_LOAD:
                        begin
                            if (closed_reg)
                            begin
                                nb_next = '0; pos_next = '0; left_next = '0;
                                lnz_i_next = '0; lnz_v_next = '0;
                                closed_next = 1'b0;
                            end
                            if (closed_reg || nb_reg < CW'(BUFFER_BYTES))
                            begin
                                if (q_data.byte_value != 8'd0)
                                begin
                                    lnz_i_next = closed_reg ? AW'(0) : nb_reg[AW-1:0];
                                    lnz_v_next = q_data.byte_value;
                                end
                                nb_next = (closed_reg ? CW'(0) : nb_reg) + CW'(1);
                            end
                            if (q_data.last_byte)
                            begin
                                closed_next = 1'b1;
                                sh_next = 3'd0;
                                state_next = S_TRIM;
                            end
                        end
                        FUNC_SKIP:
                        begin
                            ptmp = {1'b0, pos_reg} + (PW+1)'(nsat);
                            padd = (pos_reg >= CAP || ptmp >= {1'b0, CAP}) ? CAP
                                   : ptmp[PW-1:0];
                            pos_next = padd;
                            left_next = (left_reg > LW'(nsat)) ? left_reg - LW'(nsat) : '0;
                            past_next = ({1'b0, padd} > nbits);
                            state_next = S_OUT;
                        end
                        FUNC_READ:
                        begin
                            mode_next = M_READ;
                            re = 1'b1;
                            state_next = (nsat == 6'd0) ? S_OUT : S_BIT;
                        end
                        FUNC_UE, FUNC_SE:
                        begin
                            mode_next = M_PRE;
                            re = 1'b1;
                            state_next = S_BIT;
                        end
                        default:
                        begin
                            if (left_reg == '0)
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                mode_next = M_MORE;
                                spos_next = pos_reg; sleft_next = left_reg;
                                z_next = 6'd0;
                                re = 1'b1;
                                state_next = S_BIT;
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                re = 1'b1;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (!inrange) past_next = 1'b1;
                pos_next = p1;
                if (left_reg != '0) left_next = left_reg - LW'(1);
                unique case (mode_reg)
                    M_READ:
                    begin
                        acc_next = {acc_reg[30:0], bitv};
                        n_next = n_reg - 6'd1;
                    end
                    M_PRE:
                    begin
                        if (bitv)
                        begin
                            mode_next = M_READ;
                            n_next = z_reg;
                            acc_next = '0;
                        end
                        else
                        begin
                            z_next = z_reg + 6'd1;
                            if (z_reg == 6'd31) long_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (z_reg == 6'd0)
                        begin
                            z_next = 6'd1;
                            if (!bitv && !inrange)
                            begin
                                more_next = 1'b0;
                                past_next = 1'b1;
                                mode_next = M_READ;
                                n_next = 6'd0;
                                pos_next = pos_reg;
                                left_next = left_reg;
                            end
                            else if (!bitv)
                            begin
                                more_next = 1'b1;
                                mode_next = M_READ;
                                n_next = 6'd0;
                                pos_next = pos_reg;
                                left_next = left_reg;
                                past_next = past_reg;
                            end
                        end
                        else if (bitv)
                        begin
                            more_next = 1'b1;
                        end
                    end
                endcase
                if (p1 >= PW'(24) && p1[2:0] == 3'd0 && state_next == S_BIT
                    && !(mode_reg == M_MORE && z_reg == 6'd0 && !bitv))
                begin
                    ek_next = p1[AW+2:3];
                    e_ok_next = ({1'b0, p1} < nbits);
                    ra = p1[AW+2:3] - AW'(2);
                    re = 1'b1;
                    state_next = S_E0;
                end
                else
                begin
                    state_next = S_EDONE;
                end
            end
            S_E0:
            begin
                e_ok_next = e_ok_reg && (rd_reg == 8'd0);
                ra = ek_reg - AW'(1);
                re = 1'b1;
                state_next = S_E1;
            end
            S_E1:
            begin
                e_ok_next = e_ok_reg && (rd_reg == 8'd0);
                ra = ek_reg;
                re = 1'b1;
                state_next = S_E2;
            end
            S_E2:
            begin
                if (e_ok_reg && rd_reg == 8'h03)
                begin
                    ptmp = {1'b0, pos_reg} + (PW+1)'(8);
                    pos_next = (pos_reg >= CAP || ptmp >= {1'b0, CAP}) ? CAP
                               : ptmp[PW-1:0];
                end
                state_next = S_EDONE;
            end
            S_EDONE:
            begin
                state_next = S_FETCH;
                unique case (mode_reg)
                    M_READ:
                    begin
                        if (n_reg == 6'd0)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    M_PRE:
                    begin
                        if (long_reg) state_next = S_OUT;
                    end
                    default:
                    begin
                        if (more_reg || left_reg == '0)
                        begin
                            pos_next = spos_reg;
                            left_next = sleft_reg;
                            state_next = S_OUT;
                        end
                    end
                endcase
                if (mode_reg == M_READ && n_reg == 6'd0 && fn_reg == FUNC_MORE)
                begin
                    pos_next = spos_reg;
                    left_next = sleft_reg;
                end
            end
            S_TRIM:
            begin
                if (lnz_v_reg == 8'd0)
                begin
                    left_next = '0;
                    st_next = ST_EMPTY;
                    state_next = S_OUT;
                end
                else if (lnz_v_reg[sh_reg])
                begin
                    left_next = LW'({lnz_i_reg, 3'b000}) + LW'(7) - LW'(sh_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    sh_next = sh_reg + 3'd1;
                end
            end
            default:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        x = acc_reg | ((fn_reg == FUNC_UE || fn_reg == FUNC_SE) && !long_reg
                       && z_reg != 6'd0 ? (32'd1 << z_reg[4:0]) : 32'd0);
        if (fn_reg == FUNC_UE || fn_reg == FUNC_SE)
        begin
            x = long_reg ? 32'd0 : ((z_reg == 6'd0) ? 32'd0 : x - 32'd1);
        end
    end

    rsp_t out_reg;
    assign rsp.valid = ov_reg;
    assign rsp.payload = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || rsp.ready))
        begin
            out_reg.more_data <= (fn_reg == FUNC_MORE) ? more_reg : 1'b0;
            out_reg.status <= past_reg ? ST_PAST : (long_reg ? ST_LONG : st_reg);
            if (fn_reg == FUNC_READ || fn_reg == FUNC_UE)
                out_reg.value <= x;
            else if (fn_reg == FUNC_SE)
                out_reg.value <= (x == 32'd0) ? 32'd0 : (x[0] ? {1'b0, x[31:1]} + 32'd1
                                 : 32'd0 - {1'b0, x[31:1]});
            else
                out_reg.value <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; mode_reg <= M_READ; pos_reg <= '0; spos_reg <= '0;
            left_reg <= '0; sleft_reg <= '0; nb_reg <= '0; lnz_i_reg <= '0;
            lnz_v_reg <= '0; closed_reg <= 1'b0; n_reg <= '0; z_reg <= '0;
            acc_reg <= '0; fn_reg <= '0; past_reg <= 1'b0; long_reg <= 1'b0;
            more_reg <= 1'b0; sh_reg <= 3'd0; ov_reg <= 1'b0; st_reg <= ST_OK;
            e_ok_reg <= 1'b0; ek_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; mode_reg <= mode_next; pos_reg <= pos_next;
            spos_reg <= spos_next; left_reg <= left_next; sleft_reg <= sleft_next;
            nb_reg <= nb_next; lnz_i_reg <= lnz_i_next; lnz_v_reg <= lnz_v_next;
            closed_reg <= closed_next; n_reg <= n_next; z_reg <= z_next;
            acc_reg <= acc_next; fn_reg <= fn_next; past_reg <= past_next;
            long_reg <= long_next; more_reg <= more_next; sh_reg <= sh_next;
            st_reg <= st_next; e_ok_reg <= e_ok_next; ek_reg <= ek_next;
            if (state_reg == S_OUT && (!ov_reg || rsp.ready))
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/rbsp_bit_reader_exp_golomb_unit.sv =====
// Bit reader over one loaded NAL unit with Exp-Golomb decoding. A load is taken in
// the back end's idle state, the last byte then passing through stop-bit trimming;
// a skip, or a test with no bits left, goes straight to output. Reads and codes go
// one bit at a time through the byte store's single read port; at each byte
// boundary from bit 24 on, the emulation prevention check reads three bytes.
// A two-entry request queue and an output register decouple both sides.
// depends on rbgr_pkg, rbgr_if, rbgr_front, rbgr_back
`default_nettype none
module rbsp_bit_reader_exp_golomb_unit #(
    parameter int BUFFER_BYTES = 4096
) (
    input wire logic clk,
    input wire logic rst_n,
    rbgr_req_if.sink   req,
    rbgr_rsp_if.source rsp
);
    import rbgr_pkg::*;

    req_t q_data;
    logic q_valid, q_pop;

    rbgr_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
    );

    rbgr_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp)
    );
endmodule
`default_nettype wire
